// ===== rtl/lcdrc_pkg.sv =====
// lcdrc_pkg: shared types, constants and helpers for the character lcd refresh controller
// no dependencies; imported by lcdrc_fbuf, lcdrc_seq, lcdrc_out and the top level
package lcdrc_pkg;

  localparam int BUFFER_CHARS_DEF = 80;

  localparam int TPM_W   = 10;
  localparam int ROWS_W  = 3;
  localparam int COLS_W  = 6;
  localparam int CFG_W   = 10;
  localparam int CIDX_W  = 2;
  localparam int DELAY_W = 17;
  localparam int PROD_W  = 9;

  localparam logic [TPM_W-1:0]  TPM_RST  = 10'd1;
  localparam logic [ROWS_W-1:0] ROWS_RST = 3'd2;
  localparam logic [COLS_W-1:0] COLS_RST = 6'd16;

  localparam int WIDE_COLS = 20;
  localparam int MS_BOOT   = 100;
  localparam int MS_GAP    = 5;
  localparam int MS_STEP   = 1;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CURSOR = 2'd1;
  localparam logic [1:0] OP_PUT    = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_TPM  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_COLS = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] NIB_INIT   = 8'h02;
  localparam logic [7:0] CMD_FSET   = 8'h28;
  localparam logic [7:0] CMD_DCTL   = 8'h0E;
  localparam logic [7:0] CMD_ENTRY  = 8'h06;
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_ROW0   = 8'h80;
  localparam logic [7:0] CMD_ROW1   = 8'hC0;
  localparam logic [7:0] CMD_ROW2   = 8'h94;
  localparam logic [7:0] CMD_ROW3   = 8'hD4;

  typedef enum logic [6:0] {
    PH_WAIT  = 7'b0000001,
    PH_FSET  = 7'b0000010,
    PH_DCTL  = 7'b0000100,
    PH_ENTRY = 7'b0001000,
    PH_CLEAR = 7'b0010000,
    PH_PRINT = 7'b0100000,
    PH_ROW   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] row;
    logic [5:0] column;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic       register_select;
    logic [3:0] nibble;
    logic       last;
  } out_item_t;

  // one transfer queued for the lcd bus
  typedef struct packed {
    logic       lone;
    logic       rs;
    logic       from_mem;
    logic [7:0] code;
  } xfer_t;

  function automatic logic [DELAY_W-1:0] scale_ms(input logic [TPM_W-1:0] tpm, input int ms);
    logic [DELAY_W-1:0] t;
    t = (tpm == '0) ? DELAY_W'(1) : DELAY_W'(tpm);
    return DELAY_W'(t * DELAY_W'(ms));
  endfunction

endpackage

// ===== rtl/lcdrc_ram.sv =====
// lcdrc_ram: generic single write port ram with registered read
// no dependencies
module lcdrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lcdrc_fbuf.sv =====
// lcdrc_fbuf: frame buffer, one ram plus per-entry written flags
// unwritten entries read as space; depends on lcdrc_pkg and lcdrc_ram
module lcdrc_fbuf #(
  parameter int BUFFER_CHARS = lcdrc_pkg::BUFFER_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [$clog2(BUFFER_CHARS)-1:0] wr_addr,
  input  logic [7:0]                      wr_data,
  input  logic                            rd_en,
  input  logic [$clog2(BUFFER_CHARS)-1:0] rd_addr,
  output logic [7:0]                      rd_char
);
  import lcdrc_pkg::*;

  logic [BUFFER_CHARS-1:0] written_r;
  logic                    rd_written_r;
  logic [7:0]              ram_q;

  lcdrc_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_CHARS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_char = rd_written_r ? ram_q : CHAR_SPACE;

endmodule

// ===== rtl/lcdrc_seq.sv =====
// lcdrc_seq: config registers, power-up and refresh sequencer, cursor handling
// issues frame buffer accesses and bus transfers; depends on lcdrc_pkg
module lcdrc_seq #(
  parameter int BUFFER_CHARS = lcdrc_pkg::BUFFER_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lcdrc_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [lcdrc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                            acc,
  input  lcdrc_pkg::in_item_t             item,
  output logic                            xfer_v,
  output lcdrc_pkg::xfer_t                xfer,
  output logic                            wr_en,
  output logic [$clog2(BUFFER_CHARS)-1:0] wr_addr,
  output logic [7:0]                      wr_data,
  output logic                            rd_en,
  output logic [$clog2(BUFFER_CHARS)-1:0] rd_addr
);
  import lcdrc_pkg::*;

  localparam int AW = $clog2(BUFFER_CHARS);
  localparam int CW = $clog2(BUFFER_CHARS + 1);
  localparam int TW = (CW > PROD_W) ? CW : PROD_W;

  logic [TPM_W-1:0]   tpm_r;
  logic [ROWS_W-1:0]  rows_r;
  logic [COLS_W-1:0]  cols_r;
  phase_t             phase_r, phase_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt, delay_dec;
  logic [CW-1:0]      scan_r, scan_nxt;
  logic [CW-1:0]      cursor_r, cursor_nxt;

  logic [PROD_W-1:0]  prod;
  logic [TW-1:0]      total, cols_w, scan_w, idx, idx_inc, pos, cur_w, cur_inc;
  logic               wide, row_end;

  assign prod      = PROD_W'(rows_r) * PROD_W'(cols_r);
  assign total     = (TW'(prod) > TW'(BUFFER_CHARS)) ? TW'(BUFFER_CHARS) : TW'(prod);
  assign cols_w    = TW'(cols_r);
  assign wide      = (cols_r == COLS_W'(WIDE_COLS));
  assign scan_w    = TW'(scan_r);
  assign idx       = (scan_w >= total) ? '0 : scan_w;
  assign idx_inc   = idx + TW'(1);
  assign row_end   = (idx_inc == cols_w) ||
                     (wide && (idx_inc == TW'(2 * WIDE_COLS) || idx_inc == TW'(3 * WIDE_COLS))) ||
                     (idx_inc >= total);
  assign pos       = TW'(cols_r) * TW'(item.row) + TW'(item.column);
  assign cur_w     = TW'(cursor_r);
  assign cur_inc   = (cur_w < total) ? cur_w + TW'(1) : cur_w;
  assign delay_dec = delay_r - DELAY_W'(1);

  assign wr_addr = cursor_r[AW-1:0];
  assign wr_data = item.character;
  assign rd_addr = idx[AW-1:0];

  always_comb begin
    phase_nxt  = phase_r;
    delay_nxt  = delay_r;
    scan_nxt   = scan_r;
    cursor_nxt = cursor_r;
    xfer_v     = 1'b0;
    xfer       = '0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    if (acc) begin
      unique case (item.operation)
        OP_TICK: begin
          delay_nxt = delay_dec;
          if (delay_dec == '0) begin
            unique case (phase_r)
              PH_FSET: begin
                xfer_v    = 1'b1;
                xfer.code = CMD_FSET;
                delay_nxt = scale_ms(tpm_r, MS_GAP);
                phase_nxt = PH_DCTL;
              end
              PH_DCTL: begin
                xfer_v    = 1'b1;
                xfer.code = CMD_DCTL;
                delay_nxt = scale_ms(tpm_r, MS_GAP);
                phase_nxt = PH_ENTRY;
              end
              PH_ENTRY: begin
                xfer_v    = 1'b1;
                xfer.code = CMD_ENTRY;
                delay_nxt = scale_ms(tpm_r, MS_GAP);
                phase_nxt = PH_CLEAR;
              end
              PH_CLEAR: begin
                xfer_v    = 1'b1;
                xfer.code = CMD_CLEAR;
                delay_nxt = scale_ms(tpm_r, MS_BOOT);
                phase_nxt = PH_PRINT;
              end
              PH_PRINT: begin
                xfer_v        = 1'b1;
                xfer.rs       = 1'b1;
                xfer.from_mem = 1'b1;
                rd_en         = 1'b1;
                scan_nxt      = CW'(idx_inc);
                delay_nxt     = scale_ms(tpm_r, MS_STEP);
                phase_nxt     = row_end ? PH_ROW : PH_PRINT;
              end
              PH_ROW: begin
                if (scan_w >= total) begin
                  xfer_v    = 1'b1;
                  xfer.code = CMD_ROW0;
                  scan_nxt  = '0;
                end else if (scan_w == cols_w) begin
                  xfer_v    = 1'b1;
                  xfer.code = CMD_ROW1;
                end else if (wide && scan_w == TW'(2 * WIDE_COLS)) begin
                  xfer_v    = 1'b1;
                  xfer.code = CMD_ROW2;
                end else if (wide && scan_w == TW'(3 * WIDE_COLS)) begin
                  xfer_v    = 1'b1;
                  xfer.code = CMD_ROW3;
                end
                delay_nxt = scale_ms(tpm_r, MS_STEP);
                phase_nxt = PH_PRINT;
              end
              default: begin
                // power-up wait: lone nibble, then function set
                xfer_v    = 1'b1;
                xfer.lone = 1'b1;
                xfer.code = NIB_INIT;
                delay_nxt = scale_ms(tpm_r, MS_GAP);
                phase_nxt = PH_FSET;
              end
            endcase
          end
        end
        OP_CURSOR: begin
          if (pos < total) begin
            cursor_nxt = CW'(pos);
          end
        end
        OP_PUT: begin
          wr_en      = (cur_w < total);
          cursor_nxt = (cur_inc >= total) ? '0 : CW'(cur_inc);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r    <= TPM_RST;
      rows_r   <= ROWS_RST;
      cols_r   <= COLS_RST;
      phase_r  <= PH_WAIT;
      delay_r  <= scale_ms(TPM_RST, MS_BOOT);
      scan_r   <= '0;
      cursor_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      delay_r  <= delay_nxt;
      scan_r   <= scan_nxt;
      cursor_r <= cursor_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TPM:  tpm_r  <= cfg_wdata[TPM_W-1:0];
          CFG_ROWS: rows_r <= cfg_wdata[ROWS_W-1:0];
          CFG_COLS: cols_r <= cfg_wdata[COLS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    delay_r != '0)
    else $error("delay counter reached zero without reload");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r < CW'(BUFFER_CHARS))
    else $error("cursor beyond frame buffer");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r <= CW'(BUFFER_CHARS))
    else $error("scan index beyond frame buffer");

endmodule

// ===== rtl/lcdrc_out.sv =====
// lcdrc_out: skid stage for one pending transfer and the nibble output register
// splits each byte into high and low nibble beats, a lone transfer gives only its low nibble; depends on lcdrc_pkg
module lcdrc_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 xfer_v,
  input  lcdrc_pkg::xfer_t     xfer,
  input  logic [7:0]           mem_char,
  output logic                 hold,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcdrc_pkg::out_item_t out_data
);
  import lcdrc_pkg::*;

  logic       s1_v_r;
  xfer_t      s1_r;
  logic       ov_r;
  logic       hi_r;
  logic       rs_r;
  logic [7:0] code_r;
  logic       beat, free, move;

  assign beat = ov_r & ~out_stall;
  assign free = ~ov_r | (beat & ~hi_r);
  assign move = s1_v_r & free;
  assign hold = s1_v_r & ~free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      ov_r   <= 1'b0;
      hi_r   <= 1'b0;
    end else begin
      if (xfer_v) begin
        s1_v_r <= 1'b1;
      end else if (move) begin
        s1_v_r <= 1'b0;
      end
      if (move) begin
        ov_r <= 1'b1;
        hi_r <= ~s1_r.lone;
      end else if (beat) begin
        if (hi_r) begin
          hi_r <= 1'b0;
        end else begin
          ov_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer_v) begin
      s1_r <= xfer;
    end
    if (move) begin
      rs_r   <= s1_r.rs;
      code_r <= s1_r.from_mem ? mem_char : s1_r.code;
    end
  end

  assign out_valid                = ov_r;
  assign out_data.register_select = rs_r;
  assign out_data.nibble          = hi_r ? code_r[7:4] : code_r[3:0];
  assign out_data.last            = ~hi_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    xfer_v |-> (!s1_v_r || move))
    else $error("transfer issued while skid stage full");

  a_low_follows_high: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && hi_r) |=> (ov_r && !hi_r))
    else $error("low nibble did not follow high nibble");

  a_pending_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !ov_r) |=> ov_r)
    else $error("pending transfer not moved to idle output");

endmodule

// ===== rtl/char_lcd_refresh_controller.sv =====
// a tick's transfer is registered in the skid stage, then in the output register
// throughput: one item per cycle; a byte transfer holds the output for two beats, and
// input stalls only while one transfer waits in the skid stage behind a busy output
// frame buffer read is one ram read per character print tick, registered, no same-entry overlap
// reset: synchronous active low; frame buffer reads as spaces via per-entry written flags
// top level: ties sequencer, frame buffer and output stage; depends on lcdrc_pkg
module char_lcd_refresh_controller #(
  parameter int BUFFER_CHARS = lcdrc_pkg::BUFFER_CHARS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lcdrc_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lcdrc_pkg::out_item_t         out_data,
  input  logic                         cfg_we,
  input  logic [lcdrc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [lcdrc_pkg::CFG_W-1:0]  cfg_wdata
);
  import lcdrc_pkg::*;

  localparam int AW = $clog2(BUFFER_CHARS);

  logic          acc;
  logic          hold;
  logic          xfer_v;
  xfer_t         xfer;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_char;

  assign in_stall = hold;
  assign acc      = in_valid & ~hold;

  lcdrc_seq #(
    .BUFFER_CHARS (BUFFER_CHARS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .item      (in_data),
    .xfer_v    (xfer_v),
    .xfer      (xfer),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  lcdrc_fbuf #(
    .BUFFER_CHARS (BUFFER_CHARS)
  ) u_fbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_char (rd_char)
  );

  lcdrc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .xfer_v    (xfer_v),
    .xfer      (xfer),
    .mem_char  (rd_char),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for char_lcd_refresh_controller, with its own nibble predictor
// depends on lcdrc_pkg and the block rtl; a directed table runs first, then randomized phases
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdrc_pkg::*;

  localparam int         NCHARS    = BUFFER_CHARS_DEF;
  localparam int         IN_W      = $bits(in_item_t);
  localparam logic [1:0] OP_SPARE  = 2'd3;
  localparam int         HOLD_LEN  = 400;
  localparam int         SETTLE    = 16;
  localparam int         DRAIN_MAX = 20000;
  localparam int         N_DIRECT  = 23;
  localparam int         N_PHASES  = 7;

  localparam out_item_t NO_BEAT = '0;

  typedef struct packed {
    in_item_t   item;
    logic [7:0] reps;
    logic       typed;
    logic [1:0] n_typed;
    out_item_t  t0;
    out_item_t  t1;
  } stim_row_t;

  typedef struct packed {
    logic [TPM_W-1:0]  tpm;
    logic [ROWS_W-1:0] rows;
    logic [COLS_W-1:0] cols;
    logic [11:0]       items;
    logic [6:0]        tick_pct;
  } setting_t;

  // reset geometry is 2 rows of 16, so the screen holds 32 cells
  localparam stim_row_t DIRECTED_ROWS [N_DIRECT] = '{
    '{'{OP_CURSOR, 2'd3, 6'd63, 8'h00}, 8'd1,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_CURSOR, 2'd1, 6'd15, 8'hFF}, 8'd1,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_PUT,    2'd0, 6'd0,  8'hFF}, 8'd1,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_PUT,    2'd3, 6'd63, 8'h00}, 8'd1,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_SPARE,  2'd3, 6'd63, 8'hFF}, 8'd1,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_CURSOR, 2'd0, 6'd0,  8'h00}, 8'd1,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_PUT,    2'd0, 6'd0,  8'h41}, 8'd1,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd99, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_TICK,   2'd3, 6'd63, 8'hFF}, 8'd1,  1'b1, 2'd1, '{1'b0, 4'h2, 1'b1}, NO_BEAT},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd4,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd1,  1'b1, 2'd2,
      '{1'b0, 4'h2, 1'b0}, '{1'b0, 4'h8, 1'b1}},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd4,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd1,  1'b1, 2'd2,
      '{1'b0, 4'h0, 1'b0}, '{1'b0, 4'hE, 1'b1}},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd4,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd1,  1'b1, 2'd2,
      '{1'b0, 4'h0, 1'b0}, '{1'b0, 4'h6, 1'b1}},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd4,  1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd1,  1'b1, 2'd2,
      '{1'b0, 4'h0, 1'b0}, '{1'b0, 4'h1, 1'b1}},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd99, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd1,  1'b1, 2'd2,
      '{1'b1, 4'h4, 1'b0}, '{1'b1, 4'h1, 1'b1}},
    '{'{OP_TICK,   2'd2, 6'd33, 8'hA5}, 8'd40, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_CURSOR, 2'd1, 6'd0,  8'h00}, 8'd1,  1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_PUT,    2'd0, 6'd0,  8'h7E}, 8'd1,  1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{'{OP_TICK,   2'd0, 6'd0,  8'h00}, 8'd20, 1'b0, 2'd0, NO_BEAT, NO_BEAT}
  };

  // the last two phases get random geometry at run time
  localparam setting_t PHASES [N_PHASES] = '{
    '{10'd1,    3'd4, 6'd20, 12'd240,  7'd70},
    '{10'd0,    3'd1, 6'd1,  12'd60,   7'd60},
    '{10'd1000, 3'd1, 6'd40, 12'd150,  7'd97},
    '{10'd2,    3'd4, 6'd40, 12'd100,  7'd75},
    '{10'd1,    3'd3, 6'd20, 12'd80,   7'd70},
    '{10'd1,    3'd2, 6'd16, 12'd50,   7'd70},
    '{10'd1,    3'd2, 6'd16, 12'd50,   7'd70}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  char_lcd_refresh_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [7:0]        screen [NCHARS];
  phase_t            lcd_phase;
  logic [DELAY_W-1:0] tick_down;
  int                scan_pos;
  int                cursor_pos;
  logic [TPM_W-1:0]  ticks_ms;
  logic [ROWS_W-1:0] rows_used;
  logic [COLS_W-1:0] cols_used;

  out_item_t pending_nibbles [$];
  int mismatches = 0;
  int beats_seen = 0;
  int burst_left = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] beat %0d %s: got %0h, expected %0h", $time, beats_seen, what, got, want);
  endtask

  function automatic int cells_in_use();
    int cells;
    cells = int'(rows_used) * int'(cols_used);
    return (cells > NCHARS) ? NCHARS : cells;
  endfunction

  function automatic logic [DELAY_W-1:0] ms_to_ticks(input int ms);
    int scale;
    scale = (ticks_ms == '0) ? 1 : int'(ticks_ms);
    return DELAY_W'(ms * scale);
  endfunction

  task automatic split_byte(input logic rs, input logic [7:0] code,
                            output out_item_t hi, output out_item_t lo);
    hi = '{rs, code[7:4], 1'b0};
    lo = '{rs, code[3:0], 1'b1};
  endtask

  task automatic lcd_reset();
    foreach (screen[i]) screen[i] = CHAR_SPACE;
    ticks_ms   = TPM_RST;
    rows_used  = ROWS_RST;
    cols_used  = COLS_RST;
    lcd_phase  = PH_WAIT;
    tick_down  = DELAY_W'(MS_BOOT);
    scan_pos   = 0;
    cursor_pos = 0;
  endtask

  task automatic lcd_predict(input in_item_t it, output int n, output out_item_t hi,
                             output out_item_t lo, output logic skipped);
    int cells;
    int cols;
    int pos;
    cells = cells_in_use();
    cols = int'(cols_used);
    n = 0;
    hi = '0;
    lo = '0;
    skipped = 1'b0;
    case (it.operation)
      OP_TICK: begin
        tick_down = tick_down - DELAY_W'(1);
        if (tick_down == '0) begin
          case (lcd_phase)
            PH_FSET: begin
              split_byte(1'b0, CMD_FSET, hi, lo);
              n = 2;
              tick_down = ms_to_ticks(MS_GAP);
              lcd_phase = PH_DCTL;
            end
            PH_DCTL: begin
              split_byte(1'b0, CMD_DCTL, hi, lo);
              n = 2;
              tick_down = ms_to_ticks(MS_GAP);
              lcd_phase = PH_ENTRY;
            end
            PH_ENTRY: begin
              split_byte(1'b0, CMD_ENTRY, hi, lo);
              n = 2;
              tick_down = ms_to_ticks(MS_GAP);
              lcd_phase = PH_CLEAR;
            end
            PH_CLEAR: begin
              split_byte(1'b0, CMD_CLEAR, hi, lo);
              n = 2;
              tick_down = ms_to_ticks(MS_BOOT);
              lcd_phase = PH_PRINT;
            end
            PH_PRINT: begin
              if (scan_pos >= cells) scan_pos = 0;
              split_byte(1'b1, screen[scan_pos], hi, lo);
              n = 2;
              tick_down = ms_to_ticks(MS_STEP);
              scan_pos++;
              if (scan_pos == cols || scan_pos >= cells ||
                  (cols == WIDE_COLS && (scan_pos == 2 * cols || scan_pos == 3 * cols))) begin
                lcd_phase = PH_ROW;
              end
            end
            PH_ROW: begin
              if (scan_pos >= cells) begin
                split_byte(1'b0, CMD_ROW0, hi, lo);
                n = 2;
                scan_pos = 0;
              end else if (scan_pos == cols) begin
                split_byte(1'b0, CMD_ROW1, hi, lo);
                n = 2;
              end else if (cols == WIDE_COLS && scan_pos == 2 * cols) begin
                split_byte(1'b0, CMD_ROW2, hi, lo);
                n = 2;
              end else if (cols == WIDE_COLS && scan_pos == 3 * cols) begin
                split_byte(1'b0, CMD_ROW3, hi, lo);
                n = 2;
              end
              tick_down = ms_to_ticks(MS_STEP);
              lcd_phase = PH_PRINT;
            end
            default: begin
              hi = '{1'b0, NIB_INIT[3:0], 1'b1};
              n = 1;
              tick_down = ms_to_ticks(MS_GAP);
              lcd_phase = PH_FSET;
            end
          endcase
        end
      end
      OP_CURSOR: begin
        pos = cols * int'(it.row) + int'(it.column);
        if (pos < cells) cursor_pos = pos;
        else skipped = 1'b1;
      end
      OP_PUT: begin
        if (cursor_pos < cells) begin
          screen[cursor_pos] = it.character;
          cursor_pos++;
        end
        if (cursor_pos >= cells) cursor_pos = 0;
      end
      default: skipped = 1'b1;
    endcase
  endtask

  function automatic in_item_t rand_item(input int tick_pct);
    in_item_t it;
    int sel;
    int row_top;
    it = in_item_t'(IN_W'($urandom));
    sel = $urandom_range(0, 99);
    row_top = (int'(rows_used) > 4) ? 3 : int'(rows_used) - 1;
    if (sel < tick_pct) begin
      it.operation = OP_TICK;
    end else if (sel < tick_pct + (100 - tick_pct) / 2) begin
      it.operation = OP_PUT;
    end else if (sel < 97) begin
      it.operation = OP_CURSOR;
      if ($urandom_range(0, 3) != 0) begin
        it.row = 2'($urandom_range(0, row_top));
        it.column = 6'($urandom_range(0, int'(cols_used) - 1));
      end
    end else begin
      it.operation = OP_SPARE;
    end
    return it;
  endfunction

  task automatic pause_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic next_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  task automatic drive_item(input in_item_t it, input logic typed, input logic [1:0] n_typed,
                            input out_item_t t0, input out_item_t t1, output logic skipped);
    out_item_t p0;
    out_item_t p1;
    int n;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lcd_predict(it, n, p0, p1, skipped);
    if (typed) begin
      if (n_typed > 0) pending_nibbles = {pending_nibbles, t0};
      if (n_typed > 1) pending_nibbles = {pending_nibbles, t1};
    end else begin
      if (n > 0) pending_nibbles = {pending_nibbles, p0};
      if (n > 1) pending_nibbles = {pending_nibbles, p1};
    end
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    pause_input(1);
    while (pending_nibbles.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (pending_nibbles.size() != 0) begin
      flag_mismatch("beats never delivered", pending_nibbles.size(), 0);
      pending_nibbles.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TPM:  ticks_ms  = val[TPM_W-1:0];
      CFG_ROWS: rows_used = val[ROWS_W-1:0];
      CFG_COLS: cols_used = val[COLS_W-1:0];
      default: ;
    endcase
  endtask

  // receiver stall pattern, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_LEN;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 96);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= (mode_left % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_nibbles.size() == 0) begin
        flag_mismatch("unexpected beat", int'(out_data), 0);
      end else begin
        want = pending_nibbles.pop_front();
        if (out_data.register_select !== want.register_select) begin
          flag_mismatch("register_select", int'(out_data.register_select),
                        int'(want.register_select));
        end
        if (out_data.nibble !== want.nibble) begin
          flag_mismatch("nibble", int'(out_data.nibble), int'(want.nibble));
        end
        if (out_data.last !== want.last) begin
          flag_mismatch("last", int'(out_data.last), int'(want.last));
        end
      end
      beats_seen++;
    end
  end

  initial begin
    #5_000_000;
    $display("char_lcd_refresh_controller: mismatch");
    $finish;
  end

  initial begin
    stim_row_t row;
    setting_t s;
    logic skipped;
    int count;
    lcd_reset();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECT; i++) begin
      row = DIRECTED_ROWS[i];
      for (int k = 0; k < int'(row.reps); k++) begin
        next_gap();
        drive_item(row.item, row.typed, row.n_typed, row.t0, row.t1, skipped);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      s = PHASES[p];
      if (p >= 5) begin
        s.tpm  = TPM_W'($urandom_range(1, 3));
        s.rows = ROWS_W'($urandom_range(1, 4));
        s.cols = COLS_W'($urandom_range(1, 40));
      end
      drain_results();
      write_reg(CFG_TPM, CFG_W'(s.tpm));
      write_reg(CFG_ROWS, CFG_W'(s.rows));
      write_reg(CFG_COLS, CFG_W'(s.cols));
      count = 0;
      while (count < int'(s.items)) begin
        next_gap();
        drive_item(rand_item(int'(s.tick_pct)), 1'b0, 2'd0, NO_BEAT, NO_BEAT, skipped);
        if (!skipped) begin
          count++;
          // fill the block against a held-off receiver, later let it run dry
          if (p == 0 && count == 100) hold_asks++;
          if (p == 0 && count == 220) drain_results();
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("char_lcd_refresh_controller: match");
    end else begin
      $display("char_lcd_refresh_controller: mismatch");
    end
    $finish;
  end

endmodule
